[hdl/gsa_pkg.sv]
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the scalar two-operand ALU
// Opcode names and the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package gsa_pkg;

    typedef enum logic [5:0] {
        OP_ABSDIFF_I32 = 6'd0,  OP_ADDC_U32 = 6'd1,  OP_ADD_I32 = 6'd2,
        OP_ADD_U32 = 6'd3,      OP_AND_B32 = 6'd4,   OP_AND_B64 = 6'd5,
        OP_ANDN2_B32 = 6'd6,    OP_ANDN2_B64 = 6'd7, OP_ASHR_I32 = 6'd8,
        OP_ASHR_I64 = 6'd9,     OP_BFE_I32 = 6'd10,  OP_BFE_I64 = 6'd11,
        OP_BFE_U32 = 6'd12,     OP_BFE_U64 = 6'd13,  OP_BFM_B32 = 6'd14,
        OP_BFM_B64 = 6'd15,     OP_CSEL_B32 = 6'd16, OP_CSEL_B64 = 6'd17,
        OP_LSHL_B32 = 6'd18,    OP_LSHL_B64 = 6'd19, OP_LSHL1_ADD = 6'd20,
        OP_LSHL2_ADD = 6'd21,   OP_LSHL3_ADD = 6'd22, OP_LSHL4_ADD = 6'd23,
        OP_LSHR_B32 = 6'd24,    OP_LSHR_B64 = 6'd25, OP_MAX_I32 = 6'd26,
        OP_MAX_U32 = 6'd27,     OP_MIN_I32 = 6'd28,  OP_MIN_U32 = 6'd29,
        OP_MUL_HI_I32 = 6'd30,  OP_MUL_HI_U32 = 6'd31, OP_MUL_I32 = 6'd32,
        OP_NAND_B32 = 6'd33,    OP_NAND_B64 = 6'd34, OP_NOR_B32 = 6'd35,
        OP_NOR_B64 = 6'd36,     OP_OR_B32 = 6'd37,   OP_OR_B64 = 6'd38,
        OP_ORN2_B32 = 6'd39,    OP_ORN2_B64 = 6'd40, OP_PACK_HH = 6'd41,
        OP_PACK_LH = 6'd42,     OP_PACK_LL = 6'd43,  OP_SUBB_U32 = 6'd44,
        OP_SUB_I32 = 6'd45,     OP_SUB_U32 = 6'd46,  OP_XNOR_B32 = 6'd47,
        OP_XNOR_B64 = 6'd48,    OP_XOR_B32 = 6'd49,  OP_XOR_B64 = 6'd50
    } op_t;

    localparam logic [31:0] HI_HALF_MASK = 32'hffff0000;
    localparam logic [31:0] LO_HALF_MASK = 32'h0000ffff;

    // How the final stage forms the condition bit.
    typedef enum logic [1:0] {
        SCC_KEEP  = 2'd0,
        SCC_CALC  = 2'd1,
        SCC_NZERO = 2'd2
    } scc_mode_t;

    typedef struct packed {
        scc_mode_t  mode;
        logic       scc_calc;
        logic       scc_in;
        logic       written;
        logic       is_mul;
        logic       mul_hi;
    } ctl_t;

endpackage

[hdl/gsa_exec.sv]
// ----------------------------------------------------------------------------
// gsa_exec: first execute stage
// Decodes the opcode and computes every non-multiply result, and registers
// the multiplier operands.
// ----------------------------------------------------------------------------
module gsa_exec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [5:0]           cmd,
    input  logic [63:0]          src_a,
    input  logic [63:0]          src_b,
    input  logic                 scc_in,
    output logic                 valid,
    output logic [63:0]          value,
    output logic [32:0]          mul_a,
    output logic [32:0]          mul_b,
    output gsa_pkg::ctl_t        ctl
);

    logic                 valid_reg;
    logic [63:0]          value_reg, value_next;
    logic [32:0]          mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    gsa_pkg::ctl_t        ctl_reg, ctl_next;

    logic [31:0] a32, b32, r32, ext_mask32;
    logic [32:0] sum33, dif33;
    logic [5:0]  off64, len6, sh64;
    logic [4:0]  off32, sh32;
    logic [6:0]  len;
    logic [7:0]  end32, end64;
    logic [63:0] ext_mask64, bfe_v;
    logic        ext_sign;

    assign a32 = src_a[31:0];
    assign b32 = src_b[31:0];
    assign sh32 = src_b[4:0];
    assign sh64 = src_b[5:0];
    assign off32 = src_b[4:0];
    assign off64 = src_b[5:0];
    assign len = src_b[22:16];
    assign len6 = len[5:0];
    assign end32 = {3'd0, off32} + {1'b0, len};
    assign end64 = {2'd0, off64} + {1'b0, len};

    always_comb
    begin
        value_next = '0;
        mul_a_next = '0;
        mul_b_next = '0;
        sum33 = '0;
        dif33 = '0;
        r32 = '0;
        ext_mask32 = '0;
        ext_mask64 = '0;
        bfe_v = '0;
        ext_sign = 1'b0;
        ctl_next.mode = gsa_pkg::SCC_NZERO;
        ctl_next.scc_calc = 1'b0;
        ctl_next.scc_in = scc_in;
        ctl_next.written = 1'b1;
        ctl_next.is_mul = 1'b0;
        ctl_next.mul_hi = 1'b0;
        case (gsa_pkg::op_t'(cmd))
            gsa_pkg::OP_ABSDIFF_I32:
            begin
                dif33 = {a32[31], a32} - {b32[31], b32};
                r32 = dif33[32] ? (32'd0 - dif33[31:0]) : dif33[31:0];
                value_next = {32'd0, r32};
            end
            gsa_pkg::OP_ADDC_U32, gsa_pkg::OP_ADD_U32:
            begin
                sum33 = {1'b0, a32} + {1'b0, b32}
                      + {32'd0, (cmd == 6'(gsa_pkg::OP_ADDC_U32)) && scc_in};
                value_next = {32'd0, sum33[31:0]};
                ctl_next.mode = gsa_pkg::SCC_CALC;
                ctl_next.scc_calc = sum33[32];
            end
            gsa_pkg::OP_ADD_I32:
            begin
                r32 = a32 + b32;
                value_next = {32'd0, r32};
                ctl_next.mode = gsa_pkg::SCC_CALC;
                ctl_next.scc_calc = ~(a32[31] ^ b32[31]) & (a32[31] ^ r32[31]);
            end
            gsa_pkg::OP_AND_B32:   value_next = {32'd0, a32 & b32};
            gsa_pkg::OP_AND_B64:   value_next = src_a & src_b;
            gsa_pkg::OP_ANDN2_B32: value_next = {32'd0, a32 & ~b32};
            gsa_pkg::OP_ANDN2_B64: value_next = src_a & ~src_b;
            gsa_pkg::OP_ASHR_I32:
                value_next = {32'd0, 32'($signed(a32) >>> sh32)};
            gsa_pkg::OP_ASHR_I64:  value_next = $signed(src_a) >>> sh64;
            gsa_pkg::OP_BFE_I32, gsa_pkg::OP_BFE_U32:
            begin
                ext_sign = (cmd == 6'(gsa_pkg::OP_BFE_I32));
                if (len == 7'd0)
                    value_next = '0;
                else if (end32 < 8'd32)
                begin
                    ext_mask32 = ~(32'hffffffff << len[4:0]);
                    r32 = (a32 >> off32) & ext_mask32;
                    if (ext_sign && r32[len[4:0] - 5'd1])
                        r32 = r32 | ~ext_mask32;
                    value_next = {32'd0, r32};
                end
                else if (ext_sign)
                    value_next = {32'd0, 32'($signed(a32) >>> off32)};
                else
                    value_next = {32'd0, a32 >> off32};
            end
            gsa_pkg::OP_BFE_I64, gsa_pkg::OP_BFE_U64:
            begin
                ext_sign = (cmd == 6'(gsa_pkg::OP_BFE_I64));
                if (len == 7'd0)
                    value_next = '0;
                else if (end64 < 8'd64)
                begin
                    ext_mask64 = ~({64{1'b1}} << len6);
                    bfe_v = (src_a >> off64) & ext_mask64;
                    if (ext_sign && bfe_v[len6 - 6'd1])
                        bfe_v = bfe_v | ~ext_mask64;
                    value_next = bfe_v;
                end
                else if (ext_sign)
                    value_next = $signed(src_a) >>> off64;
                else
                    value_next = src_a >> off64;
            end
            gsa_pkg::OP_BFM_B32:
            begin
                value_next = {32'd0, ~(32'hffffffff << src_a[4:0]) << sh32};
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
            gsa_pkg::OP_BFM_B64:
            begin
                value_next = ~({64{1'b1}} << src_a[5:0]) << sh64;
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
            gsa_pkg::OP_CSEL_B32:
            begin
                value_next = {32'd0, scc_in ? a32 : b32};
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
            gsa_pkg::OP_CSEL_B64:
            begin
                value_next = scc_in ? src_a : src_b;
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
            gsa_pkg::OP_LSHL_B32:  value_next = {32'd0, a32 << sh32};
            gsa_pkg::OP_LSHL_B64:  value_next = src_a << sh64;
            gsa_pkg::OP_LSHL1_ADD, gsa_pkg::OP_LSHL2_ADD,
            gsa_pkg::OP_LSHL3_ADD, gsa_pkg::OP_LSHL4_ADD:
            begin
                bfe_v = ({32'd0, a32} << (cmd[2:0] - 3'd3)) + {32'd0, b32};
                value_next = {32'd0, bfe_v[31:0]};
                ctl_next.mode = gsa_pkg::SCC_CALC;
                ctl_next.scc_calc = |bfe_v[63:32];
            end
            gsa_pkg::OP_LSHR_B32:  value_next = {32'd0, a32 >> sh32};
            gsa_pkg::OP_LSHR_B64:  value_next = src_a >> sh64;
            gsa_pkg::OP_MAX_I32, gsa_pkg::OP_MAX_U32,
            gsa_pkg::OP_MIN_I32, gsa_pkg::OP_MIN_U32:
            begin
                // Flip the sign bits so one unsigned compare serves both.
                if (cmd == 6'(gsa_pkg::OP_MAX_I32) || cmd == 6'(gsa_pkg::OP_MIN_I32))
                    dif33 = {1'b0, b32 ^ 32'h80000000} - {1'b0, a32 ^ 32'h80000000};
                else
                    dif33 = {1'b0, b32} - {1'b0, a32};
                // dif33[32] means a > b.
                if (cmd == 6'(gsa_pkg::OP_MAX_I32) || cmd == 6'(gsa_pkg::OP_MAX_U32))
                    ctl_next.scc_calc = dif33[32];
                else
                    ctl_next.scc_calc = ~dif33[32] && (dif33[31:0] != 32'd0);
                value_next = {32'd0, ctl_next.scc_calc ? a32 : b32};
                ctl_next.mode = gsa_pkg::SCC_CALC;
            end
            gsa_pkg::OP_MUL_HI_I32, gsa_pkg::OP_MUL_HI_U32, gsa_pkg::OP_MUL_I32:
            begin
                ext_sign = (cmd == 6'(gsa_pkg::OP_MUL_HI_I32));
                mul_a_next = {ext_sign & a32[31], a32};
                mul_b_next = {ext_sign & b32[31], b32};
                ctl_next.is_mul = 1'b1;
                ctl_next.mul_hi = (cmd != 6'(gsa_pkg::OP_MUL_I32));
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
            gsa_pkg::OP_NAND_B32:  value_next = {32'd0, ~(a32 & b32)};
            gsa_pkg::OP_NAND_B64:  value_next = ~(src_a & src_b);
            gsa_pkg::OP_NOR_B32:   value_next = {32'd0, ~(a32 | b32)};
            gsa_pkg::OP_NOR_B64:   value_next = ~(src_a | src_b);
            gsa_pkg::OP_OR_B32:    value_next = {32'd0, a32 | b32};
            gsa_pkg::OP_OR_B64:    value_next = src_a | src_b;
            gsa_pkg::OP_ORN2_B32:  value_next = {32'd0, a32 | ~b32};
            gsa_pkg::OP_ORN2_B64:  value_next = src_a | ~src_b;
            gsa_pkg::OP_PACK_HH, gsa_pkg::OP_PACK_LH, gsa_pkg::OP_PACK_LL:
            begin
                if (cmd == 6'(gsa_pkg::OP_PACK_HH))
                    r32 = (a32 >> 16) | (b32 & gsa_pkg::HI_HALF_MASK);
                else if (cmd == 6'(gsa_pkg::OP_PACK_LH))
                    r32 = (a32 & gsa_pkg::LO_HALF_MASK) | (b32 & gsa_pkg::HI_HALF_MASK);
                else
                    r32 = (a32 & gsa_pkg::LO_HALF_MASK) | (b32 << 16);
                value_next = {32'd0, r32};
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
            gsa_pkg::OP_SUBB_U32, gsa_pkg::OP_SUB_U32:
            begin
                dif33 = {1'b0, a32} - {1'b0, b32}
                      - {32'd0, (cmd == 6'(gsa_pkg::OP_SUBB_U32)) && scc_in};
                value_next = {32'd0, dif33[31:0]};
                ctl_next.mode = gsa_pkg::SCC_CALC;
                ctl_next.scc_calc = dif33[32];
            end
            gsa_pkg::OP_SUB_I32:
            begin
                r32 = a32 - b32;
                value_next = {32'd0, r32};
                ctl_next.mode = gsa_pkg::SCC_CALC;
                ctl_next.scc_calc = (a32[31] ^ b32[31]) & (a32[31] ^ r32[31]);
            end
            gsa_pkg::OP_XNOR_B32:  value_next = {32'd0, ~(a32 ^ b32)};
            gsa_pkg::OP_XNOR_B64:  value_next = ~(src_a ^ src_b);
            gsa_pkg::OP_XOR_B32:   value_next = {32'd0, a32 ^ b32};
            gsa_pkg::OP_XOR_B64:   value_next = src_a ^ src_b;
            default:
            begin
                value_next = '0;
                ctl_next.mode = gsa_pkg::SCC_KEEP;
                ctl_next.written = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        ctl_reg   <= ctl_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign mul_a = mul_a_reg;
    assign mul_b = mul_b_reg;
    assign ctl   = ctl_reg;

endmodule

[hdl/gsa_mul.sv]
// ----------------------------------------------------------------------------
// gsa_mul: second stage
// One 33x33 signed multiply, registered, with the other results carried along.
// ----------------------------------------------------------------------------
module gsa_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [63:0]          in_value,
    input  logic [32:0]          mul_a,
    input  logic [32:0]          mul_b,
    input  gsa_pkg::ctl_t        in_ctl,
    output logic                 valid,
    output logic [63:0]          value,
    output gsa_pkg::ctl_t        ctl
);

    logic                 valid_reg;
    logic [63:0]          value_reg, value_next;
    logic [65:0]          prod;
    gsa_pkg::ctl_t        ctl_reg;

    assign prod = 66'($signed(mul_a) * $signed(mul_b));

    always_comb
    begin
        if (!in_ctl.is_mul)
            value_next = in_value;
        else if (in_ctl.mul_hi)
            value_next = {32'd0, prod[63:32]};
        else
            value_next = {32'd0, prod[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ctl_reg   <= in_ctl;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign ctl   = ctl_reg;

endmodule

[hdl/gsa_flag.sv]
// ----------------------------------------------------------------------------
// gsa_flag: final stage
// Forms the condition bit and drives the registered result ports.
// ----------------------------------------------------------------------------
module gsa_flag (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [63:0]          in_value,
    input  gsa_pkg::ctl_t        in_ctl,
    output logic                 done,
    output logic [63:0]          result,
    output logic                 scc_out,
    output logic                 scc_written
);

    logic         done_reg;
    logic [63:0]  result_reg;
    logic         scc_reg, scc_next, wr_reg;

    always_comb
    begin
        case (in_ctl.mode)
            gsa_pkg::SCC_CALC:  scc_next = in_ctl.scc_calc;
            gsa_pkg::SCC_NZERO: scc_next = |in_value;
            default:            scc_next = in_ctl.scc_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= in_value;
        scc_reg    <= scc_next;
        wr_reg     <= in_ctl.written;
    end

    assign done        = done_reg;
    assign result      = result_reg;
    assign scc_out     = scc_reg;
    assign scc_written = wr_reg;

    // A result that leaves SCC alone must pass the incoming bit through.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ctl.written |=> scc_out == $past(in_ctl.scc_in))
        else $error("unwritten SCC changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ctl.mode == gsa_pkg::SCC_KEEP |-> !in_ctl.written)
        else $error("kept SCC marked written");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ctl.mode == gsa_pkg::SCC_NZERO |=> scc_out == (result != 64'd0))
        else $error("zero flag mismatch");

endmodule

[hdl/gpu_scalar_two_operand_alu.sv]
// ----------------------------------------------------------------------------
// gpu_scalar_two_operand_alu: scalar two-source ALU
// Three-stage pipeline: execute, multiply, condition flag.
// ----------------------------------------------------------------------------
// Every command is taken when start is high; busy stays low, so one command
// may be issued each cycle. Each result appears on done, in issue order and
// held for one cycle, after passing the three register stages: decode and
// execute, the 33x33 multiplier, and condition-bit formation with the output
// register.
module gpu_scalar_two_operand_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [5:0]   cmd,
    input  logic [63:0]  src_a,
    input  logic [63:0]  src_b,
    input  logic         scc_in,
    output logic         done,
    output logic [63:0]  result,
    output logic         scc_out,
    output logic         scc_written
);

    logic                 s1_valid, s2_valid;
    logic [63:0]          s1_value, s2_value;
    logic [32:0]          s1_mul_a, s1_mul_b;
    gsa_pkg::ctl_t        s1_ctl, s2_ctl;

    assign busy = 1'b0;

    gsa_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .cmd      (cmd),
        .src_a    (src_a),
        .src_b    (src_b),
        .scc_in   (scc_in),
        .valid    (s1_valid),
        .value    (s1_value),
        .mul_a    (s1_mul_a),
        .mul_b    (s1_mul_b),
        .ctl      (s1_ctl)
    );

    gsa_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .in_value (s1_value),
        .mul_a    (s1_mul_a),
        .mul_b    (s1_mul_b),
        .in_ctl   (s1_ctl),
        .valid    (s2_valid),
        .value    (s2_value),
        .ctl      (s2_ctl)
    );

    gsa_flag u_flag (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s2_valid),
        .in_value    (s2_value),
        .in_ctl      (s2_ctl),
        .done        (done),
        .result      (result),
        .scc_out     (scc_out),
        .scc_written (scc_written)
    );

endmodule
